>>> hw/rtl/hsvrgb_pkg.sv
// Shared types, constants and channel-role decode for the HSV to RGB pixel converter.
package hsvrgb_pkg;

  // Default field widths
  localparam int CHANNEL_BITS_DEF      = 8;
  localparam int HUE_FRACTION_BITS_DEF = 4;

  // Whole-degree bits of the hue field (0..511; values from 360 up wrap around once)
  localparam int HUE_INT_BITS = 9;

  // Register stages from input accept to result
  localparam int PIPE_STAGES = 5;

  // 60-degree sectors of the color circle
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // What a channel carries in a sector: chroma, the secondary ramp, or nothing
  typedef enum logic [1:0] {
    ROLE_FULL   = 2'd0,
    ROLE_SECOND = 2'd1,
    ROLE_ZERO   = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // Stage enables handed from the pipeline control to the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // Map sector and channel to the channel's role
  function automatic role_t chan_role(sector_t sec, chan_t ch);
    role_t r;
    r = ROLE_ZERO;
    unique case (ch)
      CH_RED: begin
        unique case (sec) inside
          SEC_RED_YEL, SEC_MAG_RED: r = ROLE_FULL;
          SEC_YEL_GRN, SEC_BLU_MAG: r = ROLE_SECOND;
          default:                  r = ROLE_ZERO;
        endcase
      end
      CH_GREEN: begin
        unique case (sec) inside
          SEC_YEL_GRN, SEC_GRN_CYN: r = ROLE_FULL;
          SEC_RED_YEL, SEC_CYN_BLU: r = ROLE_SECOND;
          default:                  r = ROLE_ZERO;
        endcase
      end
      CH_BLUE: begin
        unique case (sec) inside
          SEC_CYN_BLU, SEC_BLU_MAG: r = ROLE_FULL;
          SEC_GRN_CYN, SEC_MAG_RED: r = ROLE_SECOND;
          default:                  r = ROLE_ZERO;
        endcase
      end
      default: r = ROLE_ZERO;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/hsvrgb_hue_decode.sv
// First pipeline stage: wrap the hue, find its sector and the offset inside it.
module hsvrgb_hue_decode #(
  parameter int CHANNEL_BITS      = 8,
  parameter int HUE_FRACTION_BITS = 4
) (
  input  logic                                                    clk,
  input  logic                                                    en,
  input  logic [hsvrgb_pkg::HUE_INT_BITS+HUE_FRACTION_BITS-1:0]   hue,
  input  logic [CHANNEL_BITS-1:0]                                 saturation,
  input  logic [CHANNEL_BITS-1:0]                                 brightness,
  output hsvrgb_pkg::sector_t                                     sector,
  output logic [$clog2((60 << HUE_FRACTION_BITS) + 1)-1:0]        offset,
  output logic [CHANNEL_BITS-1:0]                                 sat_q,
  output logic [CHANNEL_BITS-1:0]                                 bri_q
);
  import hsvrgb_pkg::*;

  localparam int HUE_W = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int UNITS = 60 << HUE_FRACTION_BITS;
  localparam int FULL  = 360 << HUE_FRACTION_BITS;
  localparam int U_W   = $clog2(UNITS + 1);

  logic [HUE_W-1:0] hue_wrap;
  logic [HUE_W-1:0] base;
  logic [2:0]       sec_cnt;

  // Wrap once around the circle, then compare against the sector bounds
  always_comb begin
    hue_wrap = (hue >= HUE_W'(FULL)) ? hue - HUE_W'(FULL) : hue;
    sec_cnt  = '0;
    base     = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_wrap >= HUE_W'(k * UNITS)) begin
        sec_cnt = 3'(k);
        base    = HUE_W'(k * UNITS);
      end
    end
  end

  // Register the decoded hue and pass saturation and value along
  always_ff @(posedge clk) begin
    if (en) begin
      sector <= sector_t'(sec_cnt);
      offset <= U_W'(hue_wrap - base);
      sat_q  <= saturation;
      bri_q  <= brightness;
    end
  end

endmodule

>>> hw/rtl/hsvrgb_channel.sv
// Stages two to five of one color channel: weight, products, scaling and rounding.
module hsvrgb_channel #(
  parameter int CHANNEL_BITS      = 8,
  parameter int HUE_FRACTION_BITS = 4
) (
  input  logic                                              clk,
  input  hsvrgb_pkg::pipe_en_t                              en,
  input  hsvrgb_pkg::role_t                                 role,
  input  logic                                              odd,
  input  logic [$clog2((60 << HUE_FRACTION_BITS) + 1)-1:0]  offset,
  input  logic [CHANNEL_BITS-1:0]                           sat,
  input  logic [CHANNEL_BITS-1:0]                           bri,
  output logic [CHANNEL_BITS-1:0]                           chan
);
  import hsvrgb_pkg::*;

  localparam longint unsigned MAXC  = (longint'(1) << CHANNEL_BITS) - 1;
  localparam longint unsigned UNITS = longint'(60) << HUE_FRACTION_BITS;
  localparam int              U_W   = $clog2(UNITS + 1);
  localparam longint unsigned DEN   = MAXC * UNITS;
  localparam longint unsigned HALF  = DEN / 2;
  localparam int              A_W   = CHANNEL_BITS + U_W;
  localparam int              N_W   = CHANNEL_BITS + A_W;
  localparam int              SH    = HUE_FRACTION_BITS + 2;
  localparam int              Y_W   = N_W + 1 - SH;
  // DEN = 2^SH * DivD; the odd factor goes through a reciprocal multiply
  localparam longint unsigned DivD  = 15 * MAXC;
  localparam int              D_W   = $clog2(DivD + 1);
  localparam longint unsigned RECIP = (longint'(1) << Y_W) / DivD;
  localparam int              R_W   = $clog2(RECIP + 1);
  localparam int              P_W   = Y_W + R_W;

  logic [U_W-1:0]              w;
  logic [CHANNEL_BITS+U_W-1:0] sw;
  logic [A_W-1:0]              a;
  logic [CHANNEL_BITS-1:0]     bri2;
  logic [N_W-1:0]              n;
  logic [N_W:0]                nsum;
  logic [Y_W-1:0]              y_next;
  logic [P_W-1:0]              prod;
  logic [Y_W-1:0]              y;
  logic [R_W-1:0]              qe;
  logic [R_W+D_W-1:0]          qd;
  logic [Y_W-1:0]              rem;
  logic [R_W:0]                q;

  // Stage 2: weight of the missing part of chroma, then MAXC*U - S*w
  always_comb begin
    case (role)
      ROLE_FULL:   w = '0;
      ROLE_ZERO:   w = U_W'(UNITS);
      ROLE_SECOND: w = odd ? offset : U_W'(UNITS) - offset;
      default:     w = '0;
    endcase
    sw = sat * w;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      a    <= A_W'(DEN) - A_W'(sw);
      bri2 <= bri;
    end
  end

  // Stage 3: scale by value
  always_ff @(posedge clk) begin
    if (en.s3) begin
      n <= N_W'(bri2 * a);
    end
  end

  // Stage 4: add half the divisor, drop the power of two, estimate the quotient
  always_comb begin
    nsum   = {1'b0, n} + (N_W + 1)'(HALF);
    y_next = nsum[N_W:SH];
    prod   = P_W'(y_next * R_W'(RECIP));
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      y  <= y_next;
      qe <= prod[P_W-1:Y_W];
    end
  end

  // Stage 5: correct the estimate by at most one and clamp
  always_comb begin
    qd  = qe * D_W'(DivD);
    rem = y - Y_W'(qd);
    q   = (rem >= Y_W'(DivD)) ? {1'b0, qe} + (R_W + 1)'(1) : {1'b0, qe};
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      chan <= (q > (R_W + 1)'(MAXC)) ? CHANNEL_BITS'(MAXC) : CHANNEL_BITS'(q);
    end
  end

endmodule

>>> hw/rtl/hsv_to_rgb_pixel.sv
// Pipeline: 5 register stages; an accepted request moves through stages 1 to 5 in order,
// and m_tvalid is stage 5's valid bit. Throughput: one pixel per clock unless m_tready
// stalls the output; stage 1 decodes the hue, stages 2 to 5 each hold one multiplier
// per channel (2, 4, 5 also add or compare); a stage reloads in the cycle it advances.
// Reset (rst, synchronous, active high) clears the stage valid bits only;
// data registers are not reset.
module hsv_to_rgb_pixel #(
  parameter int CHANNEL_BITS      = hsvrgb_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_FRACTION_BITS = hsvrgb_pkg::HUE_FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // hue, saturation, brightness (from bit 0 up), zero padded to bytes
  input  logic [((hsvrgb_pkg::HUE_INT_BITS + HUE_FRACTION_BITS + 2 * CHANNEL_BITS + 7) / 8)
                * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // red, green, blue (from bit 0 up), zero padded to bytes
  output logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import hsvrgb_pkg::*;

  localparam int HUE_W  = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int U_W    = $clog2((60 << HUE_FRACTION_BITS) + 1);
  localparam int OUT_W  = 3 * CHANNEL_BITS;
  localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

  logic [PIPE_STAGES:1]    vld;
  pipe_en_t                en;
  sector_t                 sector;
  logic [U_W-1:0]          offset;
  logic [CHANNEL_BITS-1:0] sat1;
  logic [CHANNEL_BITS-1:0] bri1;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en.s5 = !vld[5] || m_tready;
    en.s4 = !vld[4] || en.s5;
    en.s3 = !vld[3] || en.s4;
    en.s2 = !vld[2] || en.s3;
    en.s1 = !vld[1] || en.s2;
  end

  assign s_tready = en.s1;

  // Move valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[1] <= s_tvalid;
      if (en.s2) vld[2] <= vld[1];
      if (en.s3) vld[3] <= vld[2];
      if (en.s4) vld[4] <= vld[3];
      if (en.s5) vld[5] <= vld[4];
    end
  end

  hsvrgb_hue_decode #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_hue (
    .clk        (clk),
    .en         (en.s1),
    .hue        (s_tdata[HUE_W-1:0]),
    .saturation (s_tdata[HUE_W +: CHANNEL_BITS]),
    .brightness (s_tdata[HUE_W + CHANNEL_BITS +: CHANNEL_BITS]),
    .sector     (sector),
    .offset     (offset),
    .sat_q      (sat1),
    .bri_q      (bri1)
  );

  hsvrgb_channel #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_red (
    .clk    (clk),
    .en     (en),
    .role   (chan_role(sector, CH_RED)),
    .odd    (sector[0]),
    .offset (offset),
    .sat    (sat1),
    .bri    (bri1),
    .chan   (red)
  );

  hsvrgb_channel #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_green (
    .clk    (clk),
    .en     (en),
    .role   (chan_role(sector, CH_GREEN)),
    .odd    (sector[0]),
    .offset (offset),
    .sat    (sat1),
    .bri    (bri1),
    .chan   (green)
  );

  hsvrgb_channel #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_blue (
    .clk    (clk),
    .en     (en),
    .role   (chan_role(sector, CH_BLUE)),
    .odd    (sector[0]),
    .offset (offset),
    .sat    (sat1),
    .bri    (bri1),
    .chan   (blue)
  );

  // Pack the result
  assign m_tvalid = vld[5];
  assign m_tdata  = OUT_PW'({blue, green, red});

endmodule

>>> hw/rtl/hsvrgb_checker.sv
// Port-level checks on the HSV to RGB pixel converter, bound to its top level.
module hsvrgb_checker #(
  parameter int IN_W  = 32,
  parameter int OUT_W = 24
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);
  import hsvrgb_pkg::*;

  localparam int CNT_W = $clog2(PIPE_STAGES + 2);

  logic [CNT_W-1:0] inflight;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Count requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_STAGES))
    else $error("more requests in flight than pipeline stages");

  // Use the input payload so every port is observed
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !$isunknown(s_tdata))
    else $error("accepted request carries unknown data");

endmodule

bind hsv_to_rgb_pixel hsvrgb_checker #(
  .IN_W  (((hsvrgb_pkg::HUE_INT_BITS + HUE_FRACTION_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8),
  .OUT_W (((3 * CHANNEL_BITS + 7) / 8) * 8)
) u_hsvrgb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
